// File: hdl/rlcdw_pkg.sv
package rlcdw_pkg;

	// Panel side in pixels, used as the default of the top-level parameter.
	localparam int DEFAULT_PANEL_SIDE = 240;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_CS_ON  = 2'd1;
	localparam logic [1:0] REQ_CS_OFF = 2'd2;
	localparam logic [1:0] REQ_RESET  = 2'd3;

	// Opcodes understood by the parser.
	localparam logic [7:0] OP_SWRESET = 8'h01;
	localparam logic [7:0] OP_INVOFF  = 8'h20;
	localparam logic [7:0] OP_INVON   = 8'h21;
	localparam logic [7:0] OP_DISPOFF = 8'h28;
	localparam logic [7:0] OP_DISPON  = 8'h29;
	localparam logic [7:0] OP_CASET   = 8'h2A;
	localparam logic [7:0] OP_RASET   = 8'h2B;
	localparam logic [7:0] OP_RAMWR   = 8'h2C;
	localparam logic [7:0] OP_MADCTL  = 8'h36;
	localparam logic [7:0] OP_COLMOD  = 8'h3A;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic       dc_level;
	} rlcdw_in_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] pixel_index;
		logic [23:0] pixel_color;
		logic        clear_screen;
		logic        display_enabled;
		logic        colors_inverted;
	} rlcdw_out_t;

	// What the parser hands to the pixel stages for one word.
	typedef struct packed {
		logic        wr;
		logic [15:0] col;
		logic [15:0] row;
		logic [23:0] color;
		logic        clr;
		logic        disp;
		logic        inv;
	} rlcdw_pix_t;

	// Number of parameter bytes that follow an opcode.
	function automatic logic [2:0] param_count(input logic [7:0] op);
		logic [2:0] n;
		n = 3'd0;
		if (op == OP_CASET || op == OP_RASET) begin
			n = 3'd4;
		end else if (op == OP_MADCTL || op == OP_COLMOD) begin
			n = 3'd1;
		end
		return n;
	endfunction

endpackage

// File: hdl/rlcdw_ctrl.sv
module rlcdw_ctrl #(
	parameter int PANEL_SIDE = rlcdw_pkg::DEFAULT_PANEL_SIDE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  rlcdw_pkg::rlcdw_in_t   item,
	output rlcdw_pkg::rlcdw_pix_t  pix
);

	localparam logic [15:0] SIDE16 = 16'(PANEL_SIDE);
	localparam logic [15:0] LAST16 = 16'(PANEL_SIDE - 1);

	logic        pend_q, n_pend;
	logic [7:0]  op_q, n_op;
	logic [2:0]  exp_q, n_exp;
	logic [2:0]  recv_q, n_recv;
	logic [7:0]  pstore_q [4];
	logic [7:0]  hb_q, n_hb;
	logic        hbv_q, n_hbv;
	logic [15:0] cf_q, cl_q, rf_q, rl_q, n_cf, n_cl, n_rf, n_rl;
	logic [15:0] pc_q, pr_q, n_pc, n_pr;
	logic        mwa_q, n_mwa;
	logic        disp_q, n_disp;
	logic        inv_q, n_inv;

	logic        pst_we;
	logic [7:0]  pm [4];
	logic        exec_en;
	logic [7:0]  exec_op;
	logic        view_rst;
	logic        clr;
	logic        pixel;
	logic        inwin;
	logic        wr;
	logic [15:0] nc, nr;
	logic [15:0] v565;
	logic [23:0] c24;

	always_comb begin
		n_pend = pend_q;
		n_op   = op_q;
		n_exp  = exp_q;
		n_recv = recv_q;
		n_hb   = hb_q;
		n_hbv  = hbv_q;
		n_cf   = cf_q;
		n_cl   = cl_q;
		n_rf   = rf_q;
		n_rl   = rl_q;
		n_pc   = pc_q;
		n_pr   = pr_q;
		n_mwa  = mwa_q;
		n_disp = disp_q;
		n_inv  = inv_q;
		pst_we   = 1'b0;
		exec_en  = 1'b0;
		exec_op  = op_q;
		view_rst = 1'b0;
		clr      = 1'b0;
		pixel    = 1'b0;
		wr       = 1'b0;
		nc       = pc_q + 16'd1;
		nr       = pr_q + 16'd1;

		unique case (item.req_type)
			rlcdw_pkg::REQ_BYTE: begin
				if (!item.dc_level) begin
					if (!pend_q) begin
						n_op   = item.data_byte;
						n_recv = 3'd0;
						n_exp  = rlcdw_pkg::param_count(item.data_byte);
						if (rlcdw_pkg::param_count(item.data_byte) == 3'd0) begin
							exec_en = 1'b1;
							exec_op = item.data_byte;
						end else begin
							n_pend = 1'b1;
						end
					end else begin
						pst_we = 1'b1;
						n_recv = recv_q + 3'd1;
						if (n_recv >= exp_q) begin
							exec_en = 1'b1;
							n_pend  = 1'b0;
						end
					end
				end else if (mwa_q) begin
					if (hbv_q) begin
						n_hbv = 1'b0;
						pixel = 1'b1;
					end else begin
						n_hb  = item.data_byte;
						n_hbv = 1'b1;
					end
				end
			end
			rlcdw_pkg::REQ_CS_ON: begin
				n_pend = 1'b0;
				n_hbv  = 1'b0;
			end
			rlcdw_pkg::REQ_CS_OFF: begin
				n_mwa  = 1'b0;
				n_pend = 1'b0;
				n_hbv  = 1'b0;
			end
			default: begin
				view_rst = 1'b1;
				clr      = 1'b1;
			end
		endcase

		// Parameter bytes as they stand once this byte is stored.
		for (int i = 0; i < 4; i++) begin
			pm[i] = (pst_we && recv_q[1:0] == 2'(i)) ? item.data_byte : pstore_q[i];
		end

		if (exec_en) begin
			unique case (exec_op)
				rlcdw_pkg::OP_SWRESET: begin
					view_rst = 1'b1;
					clr      = 1'b1;
				end
				rlcdw_pkg::OP_DISPON:  n_disp = 1'b1;
				rlcdw_pkg::OP_DISPOFF: n_disp = 1'b0;
				rlcdw_pkg::OP_INVON:   n_inv  = 1'b1;
				rlcdw_pkg::OP_INVOFF:  n_inv  = 1'b0;
				rlcdw_pkg::OP_CASET: begin
					n_cf = {pm[0], pm[1]};
					n_cl = {pm[2], pm[3]};
					n_pc = {pm[0], pm[1]};
				end
				rlcdw_pkg::OP_RASET: begin
					n_rf = {pm[0], pm[1]};
					n_rl = {pm[2], pm[3]};
					n_pr = {pm[0], pm[1]};
				end
				rlcdw_pkg::OP_RAMWR: begin
					n_mwa = 1'b1;
					n_hbv = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// A pointer outside the window neither writes nor moves.
		inwin = (pc_q >= cf_q) && (pc_q <= cl_q) && (pr_q >= rf_q) && (pr_q <= rl_q);
		if (pixel && inwin) begin
			wr   = (pc_q < SIDE16) && (pr_q < SIDE16);
			n_pc = nc;
			if (nc > cl_q) begin
				n_pc = cf_q;
				n_pr = (nr > rl_q) ? rf_q : nr;
			end
		end

		if (view_rst) begin
			n_disp = 1'b0;
			n_inv  = 1'b0;
			n_mwa  = 1'b0;
			n_cf   = 16'd0;
			n_cl   = LAST16;
			n_rf   = 16'd0;
			n_rl   = LAST16;
			n_pc   = 16'd0;
			n_pr   = 16'd0;
		end
	end

	// RGB565 widened to eight bits a channel, red in the low byte.
	assign v565 = {hb_q, item.data_byte};
	assign c24  = {v565[4:0], 3'b000, v565[10:5], 2'b00, v565[15:11], 3'b000}
		^ {24{inv_q}};

	always_comb begin
		pix.wr    = wr;
		pix.col   = pc_q;
		pix.row   = pr_q;
		pix.color = c24;
		pix.clr   = clr;
		pix.disp  = n_disp;
		pix.inv   = n_inv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			op_q   <= 8'd0;
			exp_q  <= 3'd0;
			recv_q <= 3'd0;
			hb_q   <= 8'd0;
			hbv_q  <= 1'b0;
			cf_q   <= 16'd0;
			cl_q   <= LAST16;
			rf_q   <= 16'd0;
			rl_q   <= LAST16;
			pc_q   <= 16'd0;
			pr_q   <= 16'd0;
			mwa_q  <= 1'b0;
			disp_q <= 1'b0;
			inv_q  <= 1'b0;
		end else if (step) begin
			pend_q <= n_pend;
			op_q   <= n_op;
			exp_q  <= n_exp;
			recv_q <= n_recv;
			hb_q   <= n_hb;
			hbv_q  <= n_hbv;
			cf_q   <= n_cf;
			cl_q   <= n_cl;
			rf_q   <= n_rf;
			rl_q   <= n_rl;
			pc_q   <= n_pc;
			pr_q   <= n_pr;
			mwa_q  <= n_mwa;
			disp_q <= n_disp;
			inv_q  <= n_inv;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pst_we) begin
			pstore_q[recv_q[1:0]] <= item.data_byte;
		end
	end

endmodule

// File: hdl/rlcdw_shade.sv
module rlcdw_shade #(
	parameter int PANEL_SIDE = rlcdw_pkg::DEFAULT_PANEL_SIDE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	input  rlcdw_pkg::rlcdw_pix_t  pix,
	output logic                   take,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rlcdw_pkg::rlcdw_out_t  out_data
);

	localparam int CW = $clog2(PANEL_SIDE);
	localparam int SW = 2 * CW + 2;
	localparam int PW = (2 * CW + 1 > 16) ? 2 * CW + 1 : 16;
	localparam int CENTER = PANEL_SIDE / 2;
	localparam int R2 = CENTER * CENTER;

	logic                 v_s2, v_s3, ov_q;
	logic                 en_out, en3;
	rlcdw_pkg::rlcdw_pix_t p_s2;

	logic signed [SW-1:0] dx, dy;
	logic        [SW-1:0] dx2_s3, dy2_s3;
	logic        [PW-1:0] base_s3;
	logic        [CW-1:0] col_s3;
	logic                 wr_s3, clr_s3, disp_s3, inv_s3;
	logic        [23:0]   color_s3;
	logic        [SW:0]   rad_sq;
	logic        [PW-1:0] idx_full;
	logic                 outside;
	rlcdw_pkg::rlcdw_out_t out_q;

	assign en_out = !ov_q || out_ready;
	assign en3    = !v_s3 || en_out;
	assign take   = !v_s2 || en3;

	// Coordinates only matter inside the panel, where they fit in CW bits.
	assign dx = signed'(SW'(p_s2.col[CW-1:0])) - signed'(SW'(CENTER));
	assign dy = signed'(SW'(p_s2.row[CW-1:0])) - signed'(SW'(CENTER));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (take) begin
				v_s2 <= pix_valid;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				ov_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_s2 <= pix;
		end
		if (en3) begin
			dx2_s3   <= SW'(dx * dx);
			dy2_s3   <= SW'(dy * dy);
			base_s3  <= PW'(p_s2.row[CW-1:0]) * PW'(PANEL_SIDE);
			col_s3   <= p_s2.col[CW-1:0];
			wr_s3    <= p_s2.wr;
			color_s3 <= p_s2.color;
			clr_s3   <= p_s2.clr;
			disp_s3  <= p_s2.disp;
			inv_s3   <= p_s2.inv;
		end
		if (en_out) begin
			out_q <= '{
				write_valid:     wr_s3,
				pixel_index:     wr_s3 ? idx_full[15:0] : 16'd0,
				pixel_color:     (wr_s3 && !outside) ? color_s3 : 24'd0,
				clear_screen:    clr_s3,
				display_enabled: disp_s3,
				colors_inverted: inv_s3
			};
		end
	end

	assign rad_sq   = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign outside  = rad_sq > (SW + 1)'(R2);
	assign idx_full = base_s3 + PW'(col_s3);

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

// File: hdl/round_lcd_spi_command_pixel_writer.sv
// Pipeline: input register, parser stage, multiply stage and output register.
// Throughput: one word per cycle while the output side is not stalled; the parser
// updates all command state at once for each word.
// Reset: arst_n clears the command parser, the flags, the window and the write pointer at
// once, and empties every pipeline stage; the parameter bytes are not cleared.
module round_lcd_spi_command_pixel_writer #(
	parameter int PANEL_SIDE = rlcdw_pkg::DEFAULT_PANEL_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rlcdw_pkg::rlcdw_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rlcdw_pkg::rlcdw_out_t out_data
);

	// Input register: each accepted word waits here for the parser.
	logic                  vld_s1;
	rlcdw_pkg::rlcdw_in_t  in_s1;

	// The parser stage moves on when the pixel stages can take its result.
	logic                  take;
	logic                  step;
	rlcdw_pkg::rlcdw_pix_t pix;

	assign in_ready = !vld_s1 || take;
	assign step     = vld_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// The parser holds the window, the pointer and the flags, and decides whether a
	// pixel is written and in which colour.
	rlcdw_ctrl #(
		.PANEL_SIDE(PANEL_SIDE)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (in_s1),
		.pix   (pix)
	);

	// The pixel stages work out the framebuffer index and blank pixels outside the
	// centred circle; the last of them is the output register.
	rlcdw_shade #(
		.PANEL_SIDE(PANEL_SIDE)
	) u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(vld_s1),
		.pix      (pix),
		.take     (take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// File: hdl/rlcdw_checker.sv
module rlcdw_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input rlcdw_pkg::rlcdw_out_t out_data
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// The input side only stops when a result is waiting at the output.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output register");

	// Without a pixel write the index and colour are zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_valid |->
		out_data.pixel_index == 16'd0 && out_data.pixel_color == 24'd0)
		else $error("index or colour set without a pixel write");

	// A screen clear comes from a reset, which also turns display and inversion off.
	a_clear_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clear_screen |->
		!out_data.write_valid && !out_data.display_enabled && !out_data.colors_inverted)
		else $error("screen clear with a flag still set");

endmodule

bind round_lcd_spi_command_pixel_writer rlcdw_checker u_rlcdw_checker (.*);

// File: bench/tb_round_lcd_spi_command_pixel_writer.sv
module tb_round_lcd_spi_command_pixel_writer;

	// The panel size used both by the block and by the local copy of its behaviour.
	localparam int SIDE = rlcdw_pkg::DEFAULT_PANEL_SIDE;

	// Opcodes that the parser treats as plain no-parameter commands with no effect.
	localparam logic [7:0] OP_SLPOUT   = 8'h11;
	localparam logic [7:0] OP_UNLISTED = 8'hFF;

	// Roughly how many words the whole run pushes through the block.
	localparam int RANDOM_WORDS = 1350;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	rlcdw_pkg::rlcdw_in_t  in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b1;
	rlcdw_pkg::rlcdw_out_t out_data;

	round_lcd_spi_command_pixel_writer #(
		.PANEL_SIDE(SIDE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// Results still owed by the block, oldest first, one per accepted input word.
	rlcdw_pkg::rlcdw_out_t pending_results[$];
	int          errors     = 0;
	int          words_sent = 0;
	// When set, neither side inserts gaps, so the pipeline runs back to back.
	bit          steady     = 1'b0;

	// Local image of the controller: command parser, pixel assembly, window, write
	// pointer and the two display flags.
	logic        parse_busy;
	logic [7:0]  cur_op;
	logic [2:0]  param_need;
	logic [2:0]  param_got;
	logic [7:0]  param_buf [4];
	logic [7:0]  colour_hi;
	logic        colour_hi_held;
	logic [15:0] win_x0, win_x1, win_y0, win_y1;
	logic [15:0] wr_x, wr_y;
	logic        ram_wr_on;
	logic        disp_on;
	logic        inv_on;

	// Software reset and the reset pin both return the view to the whole panel. The parser
	// and any half-received pixel are deliberately left alone.
	function automatic void home_view();
		disp_on   = 1'b0;
		inv_on    = 1'b0;
		ram_wr_on = 1'b0;
		win_x0    = '0;
		win_x1    = 16'(SIDE - 1);
		win_y0    = '0;
		win_y1    = 16'(SIDE - 1);
		wr_x      = '0;
		wr_y      = '0;
	endfunction

	// Carries out a complete command; the return value says whether it asks for a clear.
	function automatic bit run_opcode(input logic [7:0] op);
		bit clr;
		clr = 1'b0;
		case (op)
		rlcdw_pkg::OP_SWRESET: begin
			home_view();
			clr = 1'b1;
		end
		rlcdw_pkg::OP_DISPON:  disp_on = 1'b1;
		rlcdw_pkg::OP_DISPOFF: disp_on = 1'b0;
		rlcdw_pkg::OP_INVON:   inv_on = 1'b1;
		rlcdw_pkg::OP_INVOFF:  inv_on = 1'b0;
		rlcdw_pkg::OP_CASET: begin
			win_x0 = {param_buf[0], param_buf[1]};
			win_x1 = {param_buf[2], param_buf[3]};
			wr_x   = win_x0;
		end
		rlcdw_pkg::OP_RASET: begin
			win_y0 = {param_buf[0], param_buf[1]};
			win_y1 = {param_buf[2], param_buf[3]};
			wr_y   = win_y0;
		end
		rlcdw_pkg::OP_RAMWR: begin
			ram_wr_on      = 1'b1;
			colour_hi_held = 1'b0;
		end
		default: ;
		endcase
		return clr;
	endfunction

	// Works out the single result that one accepted word must produce, and moves the
	// local image of the controller on by that word.
	function automatic rlcdw_pkg::rlcdw_out_t predict_word(input rlcdw_pkg::rlcdw_in_t w);
		rlcdw_pkg::rlcdw_out_t r;
		logic [15:0] rgb;
		logic [23:0] colour;
		longint      half, dx, dy;
		r = '0;
		case (w.req_type)
		rlcdw_pkg::REQ_BYTE: begin
			if (!w.dc_level) begin
				if (!parse_busy) begin
					// A fresh opcode: commands without parameters run at once.
					cur_op    = w.data_byte;
					param_got = '0;
					case (w.data_byte)
					rlcdw_pkg::OP_CASET, rlcdw_pkg::OP_RASET:   param_need = 3'd4;
					rlcdw_pkg::OP_MADCTL, rlcdw_pkg::OP_COLMOD: param_need = 3'd1;
					default:                                    param_need = 3'd0;
					endcase
					if (param_need == 3'd0) begin
						r.clear_screen = run_opcode(w.data_byte);
					end else begin
						parse_busy = 1'b1;
					end
				end else begin
					param_buf[param_got[1:0]] = w.data_byte;
					param_got = param_got + 3'd1;
					if (param_got >= param_need) begin
						r.clear_screen = run_opcode(cur_op);
						parse_busy     = 1'b0;
					end
				end
			end else if (ram_wr_on) begin
				if (colour_hi_held) begin
					colour_hi_held = 1'b0;
					rgb    = {colour_hi, w.data_byte};
					// RGB565 widened to 8 bits a channel: red low, blue high.
					colour = {rgb[4:0], 3'b000, rgb[10:5], 2'b00, rgb[15:11], 3'b000};
					if (inv_on) begin
						colour = ~colour;
					end
					// Outside the window nothing is written and the pointer stays put.
					if (wr_x >= win_x0 && wr_x <= win_x1 && wr_y >= win_y0 && wr_y <= win_y1) begin
						half = SIDE / 2;
						dx   = longint'(wr_x) - half;
						dy   = longint'(wr_y) - half;
						if (dx * dx + dy * dy > half * half) begin
							colour = '0;
						end
						if (wr_x < SIDE && wr_y < SIDE) begin
							r.write_valid = 1'b1;
							r.pixel_index = 16'(32'(wr_y) * SIDE + 32'(wr_x));
							r.pixel_color = colour;
						end
						wr_x = wr_x + 16'd1;
						if (wr_x > win_x1) begin
							wr_x = win_x0;
							wr_y = wr_y + 16'd1;
							if (wr_y > win_y1) begin
								wr_y = win_y0;
							end
						end
					end
				end else begin
					colour_hi      = w.data_byte;
					colour_hi_held = 1'b1;
				end
			end
		end
		rlcdw_pkg::REQ_CS_ON: begin
			parse_busy     = 1'b0;
			colour_hi_held = 1'b0;
		end
		rlcdw_pkg::REQ_CS_OFF: begin
			ram_wr_on      = 1'b0;
			parse_busy     = 1'b0;
			colour_hi_held = 1'b0;
		end
		rlcdw_pkg::REQ_RESET: begin
			home_view();
			r.clear_screen = 1'b1;
		end
		endcase
		r.display_enabled = disp_on;
		r.colors_inverted = inv_on;
		return r;
	endfunction

	// Offers one word to the block after a random gap and waits until it is taken. The
	// expected result is queued at the very edge at which the word is accepted.
	task automatic send_word(input logic [1:0] kind, input logic [7:0] b, input logic dc);
		int unsigned          gap;
		rlcdw_pkg::rlcdw_in_t w;
		w.req_type  = kind;
		w.data_byte = b;
		w.dc_level  = dc;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_word(w));
		words_sent++;
	endtask

	task automatic send_opcode(input logic [7:0] op);
		send_word(rlcdw_pkg::REQ_BYTE, op, 1'b0);
	endtask

	// One RGB565 pixel travels as two data bytes, high byte first.
	task automatic send_pixel(input logic [15:0] v);
		send_word(rlcdw_pkg::REQ_BYTE, v[15:8], 1'b1);
		send_word(rlcdw_pkg::REQ_BYTE, v[7:0], 1'b1);
	endtask

	// Column or row window command followed by its four parameter bytes.
	task automatic set_window(input logic [7:0] op, input logic [15:0] first,
			input logic [15:0] last);
		send_opcode(op);
		send_word(rlcdw_pkg::REQ_BYTE, first[15:8], 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, first[7:0], 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, last[15:8], 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, last[7:0], 1'b0);
	endtask

	// Display on and both inversion commands, the opcodes that take a single ignored parameter,
	// opcodes with no effect at all, and a data byte that arrives while memory write is off.
	task automatic test_flag_opcodes();
		send_opcode(rlcdw_pkg::OP_DISPON);
		send_opcode(rlcdw_pkg::OP_INVON);
		send_opcode(rlcdw_pkg::OP_INVOFF);
		send_opcode(OP_SLPOUT);
		send_opcode(rlcdw_pkg::OP_MADCTL);
		send_word(rlcdw_pkg::REQ_BYTE, 8'hFF, 1'b0);
		send_opcode(rlcdw_pkg::OP_COLMOD);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h00, 1'b0);
		send_opcode(OP_UNLISTED);
		send_word(rlcdw_pkg::REQ_BYTE, 8'hA5, 1'b1);
	endtask

	// A window straddling the right-hand edge of the panel at the top rows: the first
	// column lies outside the circle, the next one outside the panel altogether.
	task automatic test_pixel_path();
		set_window(rlcdw_pkg::OP_CASET, 16'd239, 16'd240);
		set_window(rlcdw_pkg::OP_RASET, 16'd0, 16'd1);
		send_opcode(rlcdw_pkg::OP_RAMWR);
		send_pixel(16'hFFFF);
		send_opcode(rlcdw_pkg::OP_INVON);
		send_pixel(16'h0000);
		send_pixel(16'hF81F);
		// A single pixel at the centre shows the colour remap, inverted and then plain.
		set_window(rlcdw_pkg::OP_CASET, 16'd120, 16'd120);
		set_window(rlcdw_pkg::OP_RASET, 16'd120, 16'd120);
		send_opcode(rlcdw_pkg::OP_RAMWR);
		send_pixel(16'h07E0);
		send_opcode(rlcdw_pkg::OP_INVOFF);
		send_pixel(16'hF81F);
	endtask

	// Pixel data inside a parameter list, an empty window, chip-select events halfway
	// through a pixel, and both kinds of reset.
	task automatic test_special_cases();
		send_opcode(rlcdw_pkg::OP_CASET);
		send_pixel(16'h1234);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h00, 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h00, 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h00, 1'b0);
		send_word(rlcdw_pkg::REQ_BYTE, 8'hEF, 1'b0);
		set_window(rlcdw_pkg::OP_RASET, 16'd5, 16'd4);
		send_pixel(16'hAAAA);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h55, 1'b1);
		send_word(rlcdw_pkg::REQ_CS_ON, 8'h00, 1'b0);
		set_window(rlcdw_pkg::OP_RASET, 16'd0, 16'hFFFF);
		send_pixel(16'h5555);
		send_word(rlcdw_pkg::REQ_BYTE, 8'h55, 1'b1);
		send_word(rlcdw_pkg::REQ_CS_OFF, 8'hFF, 1'b1);
		send_pixel(16'h8001);
		send_opcode(rlcdw_pkg::OP_DISPON);
		send_opcode(rlcdw_pkg::OP_SWRESET);
		send_opcode(rlcdw_pkg::OP_INVON);
		send_word(rlcdw_pkg::REQ_RESET, 8'hFF, 1'b1);
	endtask

	// Mostly well-formed traffic: windows, memory-write bursts and flag commands, mixed
	// with resets, chip-select events and loose noise words.
	task automatic test_random_traffic();
		int unsigned choice, n;
		logic [15:0] first, last;
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 99) < 3) begin
				steady = !steady;
			end
			choice = $urandom_range(0, 99);
			if (choice < 15) begin
				n = $urandom_range(0, 9);
				if (n < 8) begin
					// Small windows anywhere on the panel, some running off its edge.
					first = 16'($urandom_range(0, SIDE - 1));
					last  = first + 16'($urandom_range(0, 12));
				end else if (n < 9) begin
					first = 16'($urandom_range(1, SIDE));
					last  = first - 16'($urandom_range(1, 3));
				end else begin
					first = 16'($urandom);
					last  = 16'($urandom);
				end
				set_window($urandom_range(0, 1) ? rlcdw_pkg::OP_CASET : rlcdw_pkg::OP_RASET,
						first, last);
			end else if (choice < 65) begin
				if ($urandom_range(0, 9) < 7) begin
					send_opcode(rlcdw_pkg::OP_RAMWR);
				end
				n = $urandom_range(1, 16);
				repeat (n) send_pixel(16'($urandom));
			end else if (choice < 77) begin
				case ($urandom_range(0, 6))
				0: send_opcode(rlcdw_pkg::OP_DISPON);
				1: send_opcode(rlcdw_pkg::OP_DISPOFF);
				2: send_opcode(rlcdw_pkg::OP_INVON);
				3: send_opcode(rlcdw_pkg::OP_INVOFF);
				4: send_opcode(OP_SLPOUT);
				5: begin
					send_opcode(rlcdw_pkg::OP_MADCTL);
					send_word(rlcdw_pkg::REQ_BYTE, 8'($urandom), 1'b0);
				end
				default: begin
					send_opcode(rlcdw_pkg::OP_COLMOD);
					send_word(rlcdw_pkg::REQ_BYTE, 8'($urandom), 1'b0);
				end
				endcase
			end else if (choice < 81) begin
				if ($urandom_range(0, 1)) begin
					send_opcode(rlcdw_pkg::OP_SWRESET);
				end else begin
					send_word(rlcdw_pkg::REQ_RESET, 8'($urandom), 1'($urandom));
				end
			end else if (choice < 87) begin
				send_word($urandom_range(0, 1) ? rlcdw_pkg::REQ_CS_ON : rlcdw_pkg::REQ_CS_OFF,
						8'($urandom), 1'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_word(2'($urandom), 8'($urandom), 1'($urandom));
			end
		end
		steady = 1'b0;
	endtask

	// Result side: checks every accepted word against the oldest expectation, then draws
	// how long to hold ready low before the next one.
	rlcdw_pkg::rlcdw_out_t want;
	int unsigned           stall_left = 0;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.write_valid !== want.write_valid) begin
					$error("write_valid: expected %0d, got %0d", want.write_valid,
							out_data.write_valid);
					errors++;
				end
				if (out_data.pixel_index !== want.pixel_index) begin
					$error("pixel_index: expected %0d, got %0d", want.pixel_index,
							out_data.pixel_index);
					errors++;
				end
				if (out_data.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %h, got %h", want.pixel_color,
							out_data.pixel_color);
					errors++;
				end
				if (out_data.clear_screen !== want.clear_screen) begin
					$error("clear_screen: expected %0d, got %0d", want.clear_screen,
							out_data.clear_screen);
					errors++;
				end
				if (out_data.display_enabled !== want.display_enabled) begin
					$error("display_enabled: expected %0d, got %0d", want.display_enabled,
							out_data.display_enabled);
					errors++;
				end
				if (out_data.colors_inverted !== want.colors_inverted) begin
					$error("colors_inverted: expected %0d, got %0d", want.colors_inverted,
							out_data.colors_inverted);
					errors++;
				end
			end
			stall_left = steady ? 0 : $urandom_range(0, 4);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
			end
		end else if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0) begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		// The local image starts where the block does after reset.
		parse_busy     = 1'b0;
		cur_op         = '0;
		param_need     = '0;
		param_got      = '0;
		param_buf      = '{default: '0};
		colour_hi      = '0;
		colour_hi_held = 1'b0;
		home_view();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flag_opcodes();
		test_pixel_path();
		test_special_cases();
		test_random_traffic();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Go on waiting so that any stray extra result would still be caught.
		repeat (10) @(posedge clk);

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest correct run, with both sides stalling at every word.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
